FILE: hdl/bxds_pkg.sv
// ----------------------------------------------------------------------------
// bxds_pkg
// Shared constants and types for the box-average downscaler.
// ----------------------------------------------------------------------------
package bxds_pkg;

    // Default sizing of the line store and block side
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_FACTOR = 16;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int SUM_W      = 16;
    localparam int LW_W       = 11;
    localparam int ZF_W       = 5;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Quotient bits produced by the divider (one per stage)
    localparam int QUO_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM_FACTOR = 8'd1;

    // Register reset values
    localparam logic [LW_W-1:0] LINE_WIDTH_RST  = 11'd256;
    localparam logic [ZF_W-1:0] ZOOM_FACTOR_RST = 5'd2;

    // Per-item decode from the position tracker
    typedef struct packed {
        logic in_block;   // pixel lies in a whole block of a whole band
        logic blk_first;  // first pixel of its block: start a new sum
        logic emit;       // last pixel of its block: produce an output pixel
        logic row_end;    // output pixel closes an output row
        logic frame_end;  // output pixel closes the frame
    } pos_flags_t;

endpackage

FILE: hdl/bxds_ram.sv
// ----------------------------------------------------------------------------
// bxds_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bxds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/bxds_ctrl.sv
// ----------------------------------------------------------------------------
// bxds_ctrl
// Raster position tracker: decodes block membership and end marks per item.
// ----------------------------------------------------------------------------
module bxds_ctrl #(
    parameter int MAX_WIDTH  = bxds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = bxds_pkg::DEF_MAX_FACTOR,
    localparam int CW = $clog2(MAX_WIDTH + 1),
    localparam int FW = $clog2(MAX_FACTOR + 1),
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 restart,
    input  logic                 advance,
    input  logic [CW-1:0]        eff_width,
    input  logic [FW-1:0]        eff_factor,
    output logic [AW-1:0]        col,
    output bxds_pkg::pos_flags_t flags
);

    localparam int XW = CW + FW + 2;

    logic [CW-1:0] column_count_reg, column_count_next;
    logic [FW-1:0] block_column_reg, block_column_next;
    logic [FW-1:0] band_row_reg,     band_row_next;
    logic [CW-1:0] frame_row_reg,    frame_row_next;
    logic [CW-1:0] col_idx_reg,      col_idx_next;
    logic [CW-1:0] block_base_reg,   block_base_next;
    logic [CW-1:0] band_base_reg,    band_base_next;

    logic [XW-1:0] w_x;
    logic [XW-1:0] f_x;
    logic [XW-1:0] blk_end;
    logic [XW-1:0] band_end;
    logic          blk_fit;
    logic          band_fit;
    logic          last_col;
    logic          last_row;
    logic [CW:0]   cc_inc;
    logic [CW:0]   fr_inc;
    logic [FW:0]   bc_inc;
    logic [FW:0]   br_inc;
    logic          blk_done;
    logic          row_done;
    logic          band_done;
    logic          frame_done;

    // Decode the current position
    always_comb
    begin
        w_x      = XW'(eff_width);
        f_x      = XW'(eff_factor);
        blk_end  = XW'(block_base_reg) + f_x;
        band_end = XW'(band_base_reg) + f_x;
        blk_fit  = (blk_end <= w_x);
        band_fit = (band_end <= w_x);
        last_col = ((blk_end + f_x) > w_x);
        last_row = ((band_end + f_x) > w_x);

        flags.in_block  = blk_fit && band_fit;
        flags.blk_first = (band_row_reg == '0) && (block_column_reg == '0);
        flags.emit      = blk_fit && band_fit
                          && ((FW + 1)'(band_row_reg) + 1'b1 == (FW + 1)'(eff_factor))
                          && ((FW + 1)'(block_column_reg) + 1'b1 == (FW + 1)'(eff_factor));
        flags.row_end   = last_col;
        flags.frame_end = last_col && last_row;
        col             = col_idx_reg[AW-1:0];
    end

    // Advance the counters by one pixel; a restart clears them
    always_comb
    begin
        cc_inc     = (CW + 1)'(column_count_reg) + 1'b1;
        fr_inc     = (CW + 1)'(frame_row_reg) + 1'b1;
        bc_inc     = (FW + 1)'(block_column_reg) + 1'b1;
        br_inc     = (FW + 1)'(band_row_reg) + 1'b1;
        blk_done   = (bc_inc >= (FW + 1)'(eff_factor));
        row_done   = (cc_inc >= (CW + 1)'(eff_width));
        band_done  = (br_inc >= (FW + 1)'(eff_factor));
        frame_done = (fr_inc >= (CW + 1)'(eff_width));

        column_count_next = column_count_reg;
        block_column_next = block_column_reg;
        band_row_next     = band_row_reg;
        frame_row_next    = frame_row_reg;
        col_idx_next      = col_idx_reg;
        block_base_next   = block_base_reg;
        band_base_next    = band_base_reg;

        if (restart)
        begin
            column_count_next = '0;
            block_column_next = '0;
            band_row_next     = '0;
            frame_row_next    = '0;
            col_idx_next      = '0;
            block_base_next   = '0;
            band_base_next    = '0;
        end
        else if (advance)
        begin
            if (blk_done)
            begin
                block_column_next = '0;
                col_idx_next      = col_idx_reg + 1'b1;
                block_base_next   = CW'(cc_inc);
            end
            else
            begin
                block_column_next = FW'(bc_inc);
            end
            column_count_next = CW'(cc_inc);

            if (row_done)
            begin
                column_count_next = '0;
                block_column_next = '0;
                col_idx_next      = '0;
                block_base_next   = '0;
                frame_row_next    = CW'(fr_inc);
                if (band_done)
                begin
                    band_row_next  = '0;
                    band_base_next = CW'(fr_inc);
                end
                else
                begin
                    band_row_next = FW'(br_inc);
                end
                if (frame_done)
                begin
                    frame_row_next = '0;
                    band_row_next  = '0;
                    band_base_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            block_column_reg <= '0;
            band_row_reg     <= '0;
            frame_row_reg    <= '0;
            col_idx_reg      <= '0;
            block_base_reg   <= '0;
            band_base_reg    <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            block_column_reg <= block_column_next;
            band_row_reg     <= band_row_next;
            frame_row_reg    <= frame_row_next;
            col_idx_reg      <= col_idx_next;
            block_base_reg   <= block_base_next;
            band_base_reg    <= band_base_next;
        end
    end

endmodule

FILE: hdl/bxds_div.sv
// ----------------------------------------------------------------------------
// bxds_div
// Pipelined restoring divider: block sum over factor squared, one quotient
// bit per stage, carrying the end marks alongside.
// ----------------------------------------------------------------------------
module bxds_div #(
    parameter int MAX_FACTOR = bxds_pkg::DEF_MAX_FACTOR,
    localparam int FW = $clog2(MAX_FACTOR + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [2*FW-1:0]               divisor,
    input  logic                          in_valid,
    input  logic [bxds_pkg::SUM_W-1:0]    in_sum,
    input  logic                          in_row_end,
    input  logic                          in_frame_end,
    output logic                          out_valid,
    output logic [bxds_pkg::QUO_W-1:0]    out_quo,
    output logic                          out_row_end,
    output logic                          out_frame_end
);

    localparam int NS = bxds_pkg::QUO_W;
    localparam int XW = 2 * FW + bxds_pkg::QUO_W + bxds_pkg::SUM_W;

    logic                       valid_reg [NS+1];
    logic [bxds_pkg::SUM_W-1:0] rem_reg   [NS+1];
    logic [NS-1:0]              quo_reg   [NS+1];
    logic                       re_reg    [NS+1];
    logic                       fe_reg    [NS+1];

    // Load the first stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0] <= in_sum;
            quo_reg[0] <= '0;
            re_reg[0]  <= in_row_end;
            fe_reg[0]  <= in_frame_end;
        end
    end

    // One compare and subtract per stage, most significant quotient bit first
    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        localparam int B = NS - 1 - i;

        logic [XW-1:0]              rem_x;
        logic [XW-1:0]              trial;
        logic                       take;
        logic [bxds_pkg::SUM_W-1:0] rem_next;
        logic [NS-1:0]              quo_next;

        always_comb
        begin
            rem_x    = XW'(rem_reg[i]);
            trial    = XW'(divisor) << B;
            take     = (rem_x >= trial);
            rem_next = take ? bxds_pkg::SUM_W'(rem_x - trial) : rem_reg[i];
            quo_next = quo_reg[i];
            if (take)
            begin
                quo_next[B] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[i+1] <= rem_next;
                quo_reg[i+1] <= quo_next;
                re_reg[i+1]  <= re_reg[i];
                fe_reg[i+1]  <= fe_reg[i];
            end
        end
    end

    // Last stage doubles as the output register
    assign out_valid     = valid_reg[NS];
    assign out_quo       = quo_reg[NS];
    assign out_row_end   = re_reg[NS];
    assign out_frame_end = fe_reg[NS];

endmodule

FILE: hdl/box_average_downscaler.sv
// ----------------------------------------------------------------------------
// box_average_downscaler
// Shrinks a square 8-bit image by averaging F by F blocks; one running sum
// per output column lives in a line store RAM.
// ----------------------------------------------------------------------------
// Throughput: one pixel item per cycle while the output side takes results.
// Path: the pixel closing its block passes the line store read-modify-write
//   register, then the divider's load register and its eight stages, one
//   quotient bit each; the last stage holds the valid result.
// Reset: counters clear, line_width = 256, zoom_factor = 2; the line store is
//   not cleared, each sum is rewritten by its first pixel before it is read.
// ----------------------------------------------------------------------------
module box_average_downscaler #(
    parameter int MAX_WIDTH  = bxds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = bxds_pkg::DEF_MAX_FACTOR
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bxds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bxds_pkg::CFG_DATA_W-1:0]   cfg_data,
    // pixel input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bxds_pkg::PIX_W-1:0]        pixel_in,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bxds_pkg::PIX_W-1:0]        pixel_out,
    output logic                              row_end,
    output logic                              frame_end
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int FW = $clog2(MAX_FACTOR + 1);
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SW = bxds_pkg::SUM_W;

    logic [bxds_pkg::LW_W-1:0] line_width_reg;
    logic [bxds_pkg::ZF_W-1:0] zoom_factor_reg;
    logic [2*FW-1:0]           factor_sq_reg;

    logic                 cfg_write;
    logic                 restart;
    logic [CW-1:0]        eff_width;
    logic [FW-1:0]        eff_factor;
    logic                 advance;
    logic                 accept;
    logic [AW-1:0]        col;
    bxds_pkg::pos_flags_t flags;

    logic                          s1_valid_reg;
    logic [AW-1:0]                 s1_col_reg;
    logic [bxds_pkg::PIX_W-1:0]    s1_pix_reg;
    bxds_pkg::pos_flags_t          s1_flags_reg;
    logic                          s1_fwd_reg;
    logic [SW-1:0]                 s1_fwd_data_reg;
    logic [SW-1:0]                 ram_rdata;
    logic [SW-1:0]                 s1_base;
    logic [SW-1:0]                 s1_sum;
    logic [bxds_pkg::QUO_W-1:0]    div_quo;

    // Configuration registers; a known index restarts the frame
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign restart   = cfg_write && ((cfg_index == bxds_pkg::REG_LINE_WIDTH)
                                  || (cfg_index == bxds_pkg::REG_ZOOM_FACTOR));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg  <= bxds_pkg::LINE_WIDTH_RST;
            zoom_factor_reg <= bxds_pkg::ZOOM_FACTOR_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_index == bxds_pkg::REG_LINE_WIDTH)
            begin
                line_width_reg <= cfg_data[bxds_pkg::LW_W-1:0];
            end
            else if (cfg_index == bxds_pkg::REG_ZOOM_FACTOR)
            begin
                zoom_factor_reg <= cfg_data[bxds_pkg::ZF_W-1:0];
            end
        end
    end

    // Clamp width and factor into their working ranges
    always_comb
    begin
        if (line_width_reg == '0)
        begin
            eff_width = CW'(1);
        end
        else if (32'(line_width_reg) > MAX_WIDTH)
        begin
            eff_width = CW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = CW'(line_width_reg);
        end

        if (zoom_factor_reg == '0)
        begin
            eff_factor = FW'(1);
        end
        else if (32'(zoom_factor_reg) > MAX_FACTOR)
        begin
            eff_factor = FW'(MAX_FACTOR);
        end
        else
        begin
            eff_factor = FW'(zoom_factor_reg);
        end
    end

    // Divisor for the block average, only used deep in the pipeline
    always_ff @(posedge clk)
    begin
        factor_sq_reg <= (2 * FW)'(eff_factor) * (2 * FW)'(eff_factor);
    end

    // Whole pipeline holds while a result waits at the output
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && in_ready;

    bxds_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .advance    (accept),
        .eff_width  (eff_width),
        .eff_factor (eff_factor),
        .col        (col),
        .flags      (flags)
    );

    // Line store of running column sums
    bxds_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (advance && s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_sum),
        .re    (accept),
        .raddr (col),
        .rdata (ram_rdata)
    );

    // Accumulate stage: forward the sum written in the same cycle as the read
    always_comb
    begin
        s1_base = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
        if (s1_flags_reg.blk_first)
        begin
            s1_sum = SW'(s1_pix_reg);
        end
        else
        begin
            s1_sum = s1_base + SW'(s1_pix_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept && flags.in_block;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg      <= col;
            s1_pix_reg      <= pixel_in;
            s1_flags_reg    <= flags;
            s1_fwd_reg      <= s1_valid_reg && (s1_col_reg == col);
            s1_fwd_data_reg <= s1_sum;
        end
    end

    bxds_div #(
        .MAX_FACTOR (MAX_FACTOR)
    ) u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .divisor       (factor_sq_reg),
        .in_valid      (s1_valid_reg && s1_flags_reg.emit),
        .in_sum        (s1_sum),
        .in_row_end    (s1_flags_reg.row_end),
        .in_frame_end  (s1_flags_reg.frame_end),
        .out_valid     (out_valid),
        .out_quo       (div_quo),
        .out_row_end   (row_end),
        .out_frame_end (frame_end)
    );

    assign pixel_out = bxds_pkg::PIX_W'(div_quo);

endmodule

FILE: tb/box_average_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_average_checker
// Watches the register, pixel and result channels of the box-average
// downscaler, predicts every scaled pixel and compares it field by field.
// ----------------------------------------------------------------------------
module box_average_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [bxds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bxds_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [bxds_pkg::PIX_W-1:0]          pixel_in,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [bxds_pkg::PIX_W-1:0]          pixel_out,
    input  logic                                row_end,
    input  logic                                frame_end,
    output int                                  mismatches,
    output int                                  awaited,
    output int                                  results_checked
);

    localparam int MAX_W      = bxds_pkg::DEF_MAX_WIDTH;
    localparam int MAX_F      = bxds_pkg::DEF_MAX_FACTOR;
    localparam int PRINT_CAP  = 40;

    typedef struct packed {
        logic [bxds_pkg::PIX_W-1:0] pixel;
        logic                       row_end;
        logic                       frame_end;
    } scaled_pixel_t;

    // Shadow copy of the registers and the block's position state
    logic [bxds_pkg::LW_W-1:0]  line_width;
    logic [bxds_pkg::ZF_W-1:0]  zoom_factor;
    logic [bxds_pkg::SUM_W-1:0] col_sum [0:MAX_W-1];
    int unsigned                col_pos;
    int unsigned                blk_col;
    int unsigned                band_pos;
    int unsigned                row_pos;

    scaled_pixel_t              scaled_q [$];
    scaled_pixel_t              oldest;

    // Print one line per mismatch (up to a cap) and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Advance the position counters by one pixel and queue any block average
    task automatic step_downscaler(input logic [bxds_pkg::PIX_W-1:0] px);
        int unsigned                w;
        int unsigned                f;
        int unsigned                nblk;
        int unsigned                col;
        logic [bxds_pkg::SUM_W-1:0] sum;
        scaled_pixel_t              res;
        w = (line_width == 0) ? 1 : ((line_width > MAX_W) ? MAX_W : line_width);
        f = (zoom_factor == 0) ? 1 : ((zoom_factor > MAX_F) ? MAX_F : zoom_factor);
        nblk = w / f;
        col = col_pos / f;

        // accumulate only inside whole blocks of whole bands
        if (col < nblk && row_pos < nblk * f) begin
            if (band_pos == 0 && blk_col == 0)
                sum = px;
            else
                sum = col_sum[col] + px;
            col_sum[col] = sum;
            if (band_pos == f - 1 && blk_col == f - 1) begin
                res.pixel     = bxds_pkg::PIX_W'(sum / (f * f));
                res.row_end   = (col == nblk - 1);
                res.frame_end = (col == nblk - 1) && (row_pos == nblk * f - 1);
                scaled_q.push_back(res);
            end
        end

        // advance raster position
        blk_col++;
        if (blk_col >= f)
            blk_col = 0;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            blk_col = 0;
            band_pos++;
            if (band_pos >= f)
                band_pos = 0;
            row_pos++;
            if (row_pos >= w) begin
                row_pos = 0;
                band_pos = 0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width  = bxds_pkg::LINE_WIDTH_RST;
            zoom_factor = bxds_pkg::ZOOM_FACTOR_RST;
            col_pos     = 0;
            blk_col     = 0;
            band_pos    = 0;
            row_pos     = 0;
            for (int i = 0; i < MAX_W; i++)
                col_sum[i] = '0;
            scaled_q.delete();
            mismatches      = 0;
            results_checked = 0;
            awaited         = 0;
        end
        else
        begin
            // compare results first: they belong to older items
            if (out_valid && out_ready)
            begin
                if (scaled_q.size() == 0)
                    report_mismatch("result with nothing pending", pixel_out, 0);
                else
                begin
                    oldest = scaled_q.pop_front();
                    results_checked++;
                    if (pixel_out !== oldest.pixel)
                        report_mismatch("pixel_out", pixel_out, oldest.pixel);
                    if (row_end !== oldest.row_end)
                        report_mismatch("row_end", row_end, oldest.row_end);
                    if (frame_end !== oldest.frame_end)
                        report_mismatch("frame_end", frame_end, oldest.frame_end);
                end
            end

            // register writes restart the frame; unknown indexes are dropped
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == bxds_pkg::REG_LINE_WIDTH || cfg_index == bxds_pkg::REG_ZOOM_FACTOR)
                begin
                    if (cfg_index == bxds_pkg::REG_LINE_WIDTH)
                        line_width = cfg_data[bxds_pkg::LW_W-1:0];
                    else
                        zoom_factor = cfg_data[bxds_pkg::ZF_W-1:0];
                    col_pos  = 0;
                    blk_col  = 0;
                    band_pos = 0;
                    row_pos  = 0;
                end
            end

            if (in_valid && in_ready)
                step_downscaler(pixel_in);

            awaited = scaled_q.size();
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel frames and register writes into the box-average downscaler
// under several idling patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_ITEMS  = 950;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 20;

    localparam logic [bxds_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
    localparam logic [bxds_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

    // pixel content styles
    localparam int PIX_RANDOM  = 0;
    localparam int PIX_WHITE   = 1;
    localparam int PIX_EXTREME = 2;
    localparam int PIX_DARK    = 3;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [bxds_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [bxds_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;
    logic                               in_valid  = 1'b0;
    logic                               in_ready;
    logic [bxds_pkg::PIX_W-1:0]         pixel_in  = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b1;
    logic [bxds_pkg::PIX_W-1:0]         pixel_out;
    logic                               row_end;
    logic                               frame_end;

    int mismatches;
    int awaited;
    int results_checked;
    int send_pct     = 0;
    int recv_pct     = 0;
    int quiet_cycles = 0;
    int items_sent   = 0;
    int reg_writes   = 0;
    int phase_no     = 0;

    box_average_downscaler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

    box_average_checker ds_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pixel_in        (pixel_in),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pixel_out       (pixel_out),
        .row_end         (row_end),
        .frame_end       (frame_end),
        .mismatches      (mismatches),
        .awaited         (awaited),
        .results_checked (results_checked)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stall the result side at the rate of the current phase
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_pct);
    end

    // End the run if no channel moves an item for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: %0d cycles without a handshake, %0d results pending",
                     quiet_cycles, awaited);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [bxds_pkg::PIX_W-1:0] pick_pixel(input int style);
        case (style)
            PIX_WHITE:   return '1;
            PIX_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
            PIX_DARK:    return bxds_pkg::PIX_W'($urandom_range(0, 3));
            default:     return bxds_pkg::PIX_W'($urandom);
        endcase
    endfunction

    // Drop valid, wait out pending results and the pipeline latency
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (awaited != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Hold one register write until accepted, then drop valid and leave the channel idle
    task automatic write_reg(input logic [bxds_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bxds_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
        @(negedge clk);
    endtask

    // Hold one pixel item until accepted, with random gaps in front of it
    task automatic push_pixel(input logic [bxds_pkg::PIX_W-1:0] px);
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= px;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        items_sent++;
    endtask

    // Load a new width and factor (restarting the frame) and pick the idling mode
    task automatic start_phase(input logic [bxds_pkg::LW_W-1:0] width,
                               input logic [bxds_pkg::ZF_W-1:0] factor);
        logic [bxds_pkg::CFG_DATA_W-1:0] wdata;
        logic [bxds_pkg::CFG_DATA_W-1:0] fdata;
        wait_idle();
        wdata = bxds_pkg::CFG_DATA_W'($urandom);
        wdata[bxds_pkg::LW_W-1:0] = width;
        fdata = bxds_pkg::CFG_DATA_W'($urandom);
        fdata[bxds_pkg::ZF_W-1:0] = factor;
        if ($urandom_range(0, 4) == 0)
            write_reg(bxds_pkg::CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                      bxds_pkg::CFG_DATA_W'($urandom));
        if ($urandom_range(0, 1))
        begin
            write_reg(bxds_pkg::REG_LINE_WIDTH, wdata);
            write_reg(bxds_pkg::REG_ZOOM_FACTOR, fdata);
        end
        else
        begin
            write_reg(bxds_pkg::REG_ZOOM_FACTOR, fdata);
            write_reg(bxds_pkg::REG_LINE_WIDTH, wdata);
        end
        case (idle_mode_t'(phase_no % 4))
            IDLE_SENDER:   begin send_pct = 56; recv_pct = 0;  end
            IDLE_RECEIVER: begin send_pct = 0;  recv_pct = 56; end
            IDLE_BOTH:     begin send_pct = 7;  recv_pct = 7;  end
            default:       begin send_pct = 0;  recv_pct = 0;  end
        endcase
        phase_no++;
    endtask

    initial
    begin
        int                        sel;
        int                        n;
        int                        style;
        int                        rand_sent;
        logic [bxds_pkg::LW_W-1:0] w;
        logic [bxds_pkg::ZF_W-1:0] f;
        rand_sent = 0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero width and zero factor both act as one: every pixel is a result
        start_phase(0, 0);
        push_pixel(8'h00);
        push_pixel(8'hFF);
        push_pixel(8'hA5);

        // partial column and partial band are consumed silently; full sum
        start_phase(3, 2);
        repeat (9) push_pixel(8'hFF);

        // factor wider than the image: nothing is ever produced
        start_phase(2, 5);
        repeat (4) push_pixel(pick_pixel(PIX_RANDOM));

        // unknown register index must not restart the frame
        start_phase(4, 1);
        push_pixel(8'h5A);
        push_pixel(8'h0F);
        wait_idle();
        write_reg(REG_UNUSED_HI, '1);
        push_pixel(8'hF0);
        push_pixel(8'hC3);

        // random settings, mostly small frames, a few at the extremes
        while (rand_sent < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 19);
            style = ($urandom_range(0, 3) == 0) ? $urandom_range(PIX_WHITE, PIX_DARK)
                                                : PIX_RANDOM;
            if (sel <= 12)
            begin
                w = bxds_pkg::LW_W'($urandom_range(1, 12));
                f = bxds_pkg::ZF_W'($urandom_range(1, 4));
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, w * w) : w * w;
            end
            else if (sel <= 14)
            begin
                w = bxds_pkg::LW_W'($urandom_range(0, 1) ? 1024
                                                        : $urandom_range(1025, 2047));
                f = bxds_pkg::ZF_W'($urandom_range(0, 2));
                n = $urandom_range(30, 80);
            end
            else if (sel == 15)
            begin
                w = 16;
                f = bxds_pkg::ZF_W'($urandom_range(16, 31));
                n = 256;
            end
            else if (sel == 16)
            begin
                w = bxds_pkg::LW_W'($urandom_range(0, 5));
                f = bxds_pkg::ZF_W'($urandom_range((w < 2) ? 2 : w + 1, 31));
                n = $urandom_range(5, 20);
            end
            else if (sel == 17)
            begin
                w = bxds_pkg::LW_W'($urandom_range(0, 6));
                f = 0;
                n = (w == 0) ? 3 : w * w;
            end
            else
            begin
                w = bxds_pkg::LW_W'($urandom_range(13, 40));
                f = bxds_pkg::ZF_W'($urandom_range(2, 8));
                n = w * f + $urandom_range(0, w);
            end
            if (n > RANDOM_ITEMS - rand_sent)
                n = RANDOM_ITEMS - rand_sent;
            start_phase(w, f);
            repeat (n) push_pixel(pick_pixel(style));
            rand_sent += n;
        end

        wait_idle();
        $display("Sent %0d pixel items over %0d register settings (%0d register writes),",
                 items_sent, phase_no, reg_writes);
        $display("widths 0..2047 and factors 0..31, %0d scaled pixels compared.",
                 results_checked);
        if (mismatches == 0 && awaited == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/bxds_pkg.sv
hdl/bxds_ram.sv
hdl/bxds_ctrl.sv
hdl/bxds_div.sv
hdl/box_average_downscaler.sv
tb/box_average_checker.sv
tb/testbench.sv
